// ===== sv/bdg_pkg.sv =====
// ----------------------------------------------------------------------------
// bdg_pkg
// Shared types and constants for the button debounce and gesture decoder.
// ----------------------------------------------------------------------------
package bdg_pkg;

    // register file geometry
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned THR_W      = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CNT_W      = 4;

    // register byte addresses
    localparam logic [CFG_ADDR_W-1:0] ADDR_DEBOUNCE  = 4'h0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_MULTI_GAP = 4'h4;
    localparam logic [CFG_ADDR_W-1:0] ADDR_LONG_HOLD = 4'h8;

    // register reset values
    localparam logic [THR_W-1:0] DEBOUNCE_RST  = 16'd20;
    localparam logic [THR_W-1:0] MULTI_GAP_RST = 16'd250;
    localparam logic [THR_W-1:0] LONG_HOLD_RST = 16'd2000;

    // press count saturation
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // one input beat
    typedef struct packed {
        logic              raw_level;
        logic [TIME_W-1:0] now_ms;
    } bdg_in_t;

    // one result beat
    typedef struct packed {
        logic             button_level;
        logic             gesture_valid;
        logic [CNT_W-1:0] gesture_presses;
        logic             gesture_long;
    } bdg_out_t;

    // thresholds handed from the register file to the engine
    typedef struct packed {
        logic [THR_W-1:0] deb_thr;
        logic [THR_W-1:0] gap_thr;
        logic [THR_W-1:0] hold_thr;
    } bdg_cfg_t;

endpackage

// ===== sv/bdg_cfg.sv =====
// ----------------------------------------------------------------------------
// bdg_cfg
// APB-style register file holding the three timing thresholds.
// ----------------------------------------------------------------------------
module bdg_cfg
    import bdg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output bdg_cfg_t              cfg
);

    bdg_cfg_t cfg_reg;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deb_thr  <= DEBOUNCE_RST;
            cfg_reg.gap_thr  <= MULTI_GAP_RST;
            cfg_reg.hold_thr <= LONG_HOLD_RST;
        end
        else if (wr_en)
        begin
            case (paddr)
                ADDR_DEBOUNCE:  cfg_reg.deb_thr  <= pwdata[THR_W-1:0];
                ADDR_MULTI_GAP: cfg_reg.gap_thr  <= pwdata[THR_W-1:0];
                ADDR_LONG_HOLD: cfg_reg.hold_thr <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (paddr)
            ADDR_DEBOUNCE:  prdata = {{(CFG_DATA_W-THR_W){1'b0}}, cfg_reg.deb_thr};
            ADDR_MULTI_GAP: prdata = {{(CFG_DATA_W-THR_W){1'b0}}, cfg_reg.gap_thr};
            ADDR_LONG_HOLD: prdata = {{(CFG_DATA_W-THR_W){1'b0}}, cfg_reg.hold_thr};
            default:        prdata = '0;
        endcase
    end

endmodule

// ===== sv/bdg_engine.sv =====
// ----------------------------------------------------------------------------
// bdg_engine
// Debounce and burst state with the single-pass update for one sample.
// ----------------------------------------------------------------------------
module bdg_engine
    import bdg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  bdg_in_t  smp,
    input  bdg_cfg_t cfg,
    output bdg_out_t res
);

    logic              last_raw_reg,      last_raw_next;
    logic [TIME_W-1:0] change_time_reg,   change_time_next;
    logic              deb_level_reg,     deb_level_next;
    logic [TIME_W-1:0] press_start_reg,   press_start_next;
    logic [CNT_W-1:0]  burst_count_reg,   burst_count_next;
    logic [TIME_W-1:0] release_time_reg,  release_time_next;
    logic              burst_active_reg,  burst_active_next;
    logic              long_fired_reg,    long_fired_next;

    logic              deb_flip;
    logic              went_down;
    logic              went_up;
    logic [CNT_W-1:0]  count_a;
    logic              active_a;
    logic              lf_a;
    logic              long_fire;
    logic              lf_b;
    logic              end_long;
    logic [CNT_W-1:0]  count_b;
    logic              active_b;
    logic              short_fire;

    // debounce
    always_comb
    begin
        last_raw_next    = smp.raw_level;
        change_time_next = (smp.raw_level != last_raw_reg) ? smp.now_ms : change_time_reg;
        deb_flip = (smp.raw_level != deb_level_reg) &&
                   ((smp.now_ms - change_time_next) >= {{(TIME_W-THR_W){1'b0}},
                                                       cfg.deb_thr});
        deb_level_next    = deb_flip ? smp.raw_level : deb_level_reg;
        went_down         = deb_flip && smp.raw_level;
        went_up           = deb_flip && !smp.raw_level;
        press_start_next  = went_down ? smp.now_ms : press_start_reg;
        release_time_next = went_up ? smp.now_ms : release_time_reg;
    end

    // burst collection: press, long hold, release, gap lapse
    always_comb
    begin
        count_a  = burst_count_reg;
        if (went_down && (burst_count_reg != CNT_MAX))
        begin
            count_a = burst_count_reg + 1'b1;
        end
        active_a = burst_active_reg || went_down;
        lf_a     = long_fired_reg && !went_down;

        long_fire = active_a && deb_level_next && !lf_a &&
                    ((smp.now_ms - press_start_next) >= {{(TIME_W-THR_W){1'b0}},
                                                        cfg.hold_thr});
        lf_b      = lf_a || long_fire;

        end_long = went_up && lf_b;
        count_b  = end_long ? '0 : count_a;
        active_b = end_long ? 1'b0 : active_a;

        short_fire = active_b && !deb_level_next && !lf_b &&
                     ((smp.now_ms - release_time_next) >= {{(TIME_W-THR_W){1'b0}},
                                                          cfg.gap_thr});

        burst_count_next  = short_fire ? '0 : count_b;
        burst_active_next = short_fire ? 1'b0 : active_b;
        long_fired_next   = lf_b;

        res.button_level    = deb_level_next;
        res.gesture_valid   = long_fire || short_fire;
        res.gesture_long    = long_fire;
        res.gesture_presses = long_fire  ? count_a :
                              short_fire ? count_b : '0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg     <= 1'b0;
            change_time_reg  <= '0;
            deb_level_reg    <= 1'b0;
            press_start_reg  <= '0;
            burst_count_reg  <= '0;
            release_time_reg <= '0;
            burst_active_reg <= 1'b0;
            long_fired_reg   <= 1'b0;
        end
        else if (step)
        begin
            last_raw_reg     <= last_raw_next;
            change_time_reg  <= change_time_next;
            deb_level_reg    <= deb_level_next;
            press_start_reg  <= press_start_next;
            burst_count_reg  <= burst_count_next;
            release_time_reg <= release_time_next;
            burst_active_reg <= burst_active_next;
            long_fired_reg   <= long_fired_next;
        end
    end

endmodule

// ===== sv/button_debounce_gesture_decoder_core.sv =====
// ----------------------------------------------------------------------------
// button_debounce_gesture_decoder_core
// Debounces timestamped button samples and reports multi-click and
// long-press gestures, one result beat per sample beat.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  sample   | smp_valid/smp_stall  | smp_data : raw_level, now_ms
//  result   | res_valid/res_stall  | res_data : level and gesture fields
//  config   | APB psel/penable     | paddr, pwdata, prdata, pready
//
//  one beat per cycle sustained while res_stall is low; a sample passes the
//  input register then the result register, with the state update between them
//  reset clears thresholds to 20/250/2000 ms and all burst state to zero
//  a stalled result holds; the input register keeps taking beats while
//  the result register can drain, so smp_stall rises only when both are full
// ----------------------------------------------------------------------------
module button_debounce_gesture_decoder_core
    import bdg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  smp_valid,
    output logic                  smp_stall,
    input  bdg_in_t               smp_data,
    output logic                  res_valid,
    input  logic                  res_stall,
    output bdg_out_t              res_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    bdg_cfg_t cfg;
    logic     in_valid_reg;
    bdg_in_t  in_data_reg;
    logic     out_valid_reg;
    bdg_out_t out_data_reg;
    bdg_out_t step_res;
    logic     out_free;
    logic     step;

    // pipeline advance
    assign out_free  = !out_valid_reg || !res_stall;
    assign step      = in_valid_reg && out_free;
    assign smp_stall = in_valid_reg && !out_free;
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    // register file
    bdg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state update for the registered sample
    bdg_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .smp   (in_data_reg),
        .cfg   (cfg),
        .res   (step_res)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!smp_stall)
        begin
            in_valid_reg <= smp_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (!smp_stall && smp_valid)
        begin
            in_data_reg <= smp_data;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= step_res;
        end
    end

endmodule

// ===== sv/bdg_checker.sv =====
// ----------------------------------------------------------------------------
// bdg_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bdg_checker
    import bdg_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     smp_stall,
    input logic     res_valid,
    input logic     res_stall,
    input bdg_out_t res_data
);

    // stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        smp_stall |-> res_valid && res_stall)
        else $error("sample stalled without a stalled result");

    // no gesture means empty gesture fields
    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.gesture_valid |->
            res_data.gesture_presses == '0 && !res_data.gesture_long)
        else $error("gesture fields set without a gesture");

    // long gesture only while pressed, short only while released
    a_level_match: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.gesture_valid |->
            res_data.gesture_long == res_data.button_level)
        else $error("gesture kind disagrees with debounced level");

    // a gesture always carries at least one press
    a_presses: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.gesture_valid |-> res_data.gesture_presses != '0)
        else $error("gesture with zero presses");

endmodule

bind button_debounce_gesture_decoder_core bdg_checker u_bdg_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button debounce and gesture decoder. A
// predictor tracks debounce and burst state per accepted sample beat and
// queues the expected result; the monitor checks every result beat field by
// field. Stimulus covers directed edge cases at the reset thresholds, then
// random click bursts, long holds and noise over several threshold settings
// and idle/stall mixes.
// ----------------------------------------------------------------------------
module tb
    import bdg_pkg::*;
;

    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned TIMEOUT_NS      = 4_000_000;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // block ports
    logic                  smp_valid = 1'b0;
    logic                  smp_stall;
    bdg_in_t               smp_data  = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    bdg_out_t              res_data;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // stimulus and scoreboard bookkeeping
    bdg_in_t     sample_q [$];
    bdg_out_t    gesture_q [$];
    bdg_out_t    want_res;
    int unsigned queued_cnt     = 0;
    int unsigned taken_cnt      = 0;
    int unsigned err_cnt        = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic [31:0] clock_ms       = '0;

    // long receiver hold-off request
    logic        hold_arm  = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    // predictor copy of the thresholds
    logic [THR_W-1:0] thr_debounce = DEBOUNCE_RST;
    logic [THR_W-1:0] thr_gap      = MULTI_GAP_RST;
    logic [THR_W-1:0] thr_hold     = LONG_HOLD_RST;

    // predictor copy of the decoder state
    logic              prev_raw    = 1'b0;
    logic [TIME_W-1:0] raw_edge_ms = '0;
    logic              level_q     = 1'b0;
    logic [TIME_W-1:0] press_ms    = '0;
    logic [CNT_W-1:0]  press_cnt   = '0;
    logic [TIME_W-1:0] release_ms  = '0;
    logic              burst_live  = 1'b0;
    logic              long_done   = 1'b0;

    // directed samples and per-phase settings
    logic [32:0] warmup [25] = '{
        {1'b0, 32'd0},    {1'b1, 32'd5},    {1'b0, 32'd10},   {1'b1, 32'd12},
        {1'b1, 32'd32},   {1'b0, 32'd100},  {1'b0, 32'd119},  {1'b0, 32'd120},
        {1'b0, 32'd369},  {1'b0, 32'd370},  {1'b1, 32'd1000}, {1'b1, 32'd1020},
        {1'b1, 32'd3019}, {1'b1, 32'd3020}, {1'b1, 32'd5000}, {1'b0, 32'd5100},
        {1'b0, 32'd5120}, {1'b0, 32'd9000}, {1'b1, 32'hFFFF_FFF0},
        {1'b1, 32'h0000_0004}, {1'b0, 32'h0000_0010}, {1'b0, 32'h0000_0024},
        {1'b0, 32'h0000_0010}, {1'b1, 32'hFFFF_FFFF}, {1'b1, 32'h0000_0000}
    };
    int unsigned ph_deb  [7] = '{3, 0, 65535, 2, 5, 10, 0};
    int unsigned ph_gap  [7] = '{40, 0, 65535, 60, 30, 100, 0};
    int unsigned ph_hold [7] = '{120, 0, 65535, 500, 80, 300, 0};
    int unsigned ph_send [7] = '{0, 51, 0, 7, 51, 0, 7};
    int unsigned ph_recv [7] = '{0, 0, 51, 7, 0, 51, 7};
    int unsigned ph_end  [7] = '{330, 480, 630, 880, 1080, 1280, 1640};

    button_debounce_gesture_decoder_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // wrapping millisecond difference
    function automatic logic [TIME_W-1:0] elapsed(logic [TIME_W-1:0] now,
                                                  logic [TIME_W-1:0] since);
        return now - since;
    endfunction

    // debounce and gesture prediction for one sample beat
    function automatic bdg_out_t decode_sample(bdg_in_t s);
        bdg_out_t r;
        logic     pressed_now;
        logic     released_now;
        r            = '0;
        pressed_now  = 1'b0;
        released_now = 1'b0;

        // debounce: level follows once the raw level held long enough
        if (s.raw_level != prev_raw)
        begin
            prev_raw    = s.raw_level;
            raw_edge_ms = s.now_ms;
        end
        if (s.raw_level != level_q &&
            elapsed(s.now_ms, raw_edge_ms) >= {16'd0, thr_debounce})
        begin
            level_q = s.raw_level;
            if (s.raw_level)
            begin
                press_ms    = s.now_ms;
                pressed_now = 1'b1;
            end
            else
                released_now = 1'b1;
        end

        // new press joins the burst
        if (pressed_now)
        begin
            if (press_cnt != CNT_MAX)
                press_cnt = press_cnt + 1'b1;
            burst_live = 1'b1;
            long_done  = 1'b0;
        end

        // long hold fires while still down
        if (burst_live && level_q && !long_done &&
            elapsed(s.now_ms, press_ms) >= {16'd0, thr_hold})
        begin
            r.gesture_valid   = 1'b1;
            r.gesture_presses = press_cnt;
            r.gesture_long    = 1'b1;
            long_done         = 1'b1;
        end

        // release after a long hold closes the burst
        if (released_now)
        begin
            release_ms = s.now_ms;
            if (long_done)
            begin
                burst_live = 1'b0;
                press_cnt  = '0;
            end
        end

        // gap lapsed with the button up: short gesture
        if (burst_live && !level_q && !long_done &&
            elapsed(s.now_ms, release_ms) >= {16'd0, thr_gap})
        begin
            r.gesture_valid   = 1'b1;
            r.gesture_presses = press_cnt;
            r.gesture_long    = 1'b0;
            burst_live        = 1'b0;
            press_cnt         = '0;
        end

        r.button_level = level_q;
        return r;
    endfunction

    // sample driver: one beat per accept, payload held while stalled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (smp_valid && !smp_stall)
            begin
                gesture_q.push_back(decode_sample(smp_data));
                taken_cnt = taken_cnt + 1;
            end
            if (!smp_valid || !smp_stall)
            begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    smp_data  <= sample_q.pop_front();
                    smp_valid <= 1'b1;
                end
                else
                    smp_valid <= 1'b0;
            end
        end
    end

    // result stall: random, or one long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_arm != hold_seen)
        begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_OFF_CYCLES;
            res_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            err_cnt = err_cnt + 1;
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (gesture_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, expected none, actual %h",
                         $time, res_data);
                err_cnt = err_cnt + 1;
            end
            else
            begin
                want_res = gesture_q.pop_front();
                check_field("button_level", 32'(want_res.button_level),
                            32'(res_data.button_level));
                check_field("gesture_valid", 32'(want_res.gesture_valid),
                            32'(res_data.gesture_valid));
                check_field("gesture_presses", 32'(want_res.gesture_presses),
                            32'(res_data.gesture_presses));
                check_field("gesture_long", 32'(want_res.gesture_long),
                            32'(res_data.gesture_long));
            end
        end
    end

    // wait for every queued sample to be taken and answered
    task automatic wait_idle();
        while (taken_cnt != queued_cnt || gesture_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write, then read back
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [THR_W-1:0] val);
        logic [CFG_DATA_W-1:0] rd;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom()), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (addr)
            ADDR_DEBOUNCE:  thr_debounce = val;
            ADDR_MULTI_GAP: thr_gap      = val;
            ADDR_LONG_HOLD: thr_hold     = val;
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rd = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[THR_W-1:0] !== val)
        begin
            $display("%0t: readback at %h, expected %0d, actual %0d", $time, addr, val,
                     rd[THR_W-1:0]);
            err_cnt = err_cnt + 1;
        end
    endtask

    // stimulus builders
    task automatic emit(input logic lvl, input logic [31:0] t);
        sample_q.push_back({lvl, t});
        queued_cnt = queued_cnt + 1;
        clock_ms   = t;
    endtask

    // a few samples at one level spread over dur ms
    task automatic hold_level(input logic lvl, input int unsigned dur);
        logic [31:0] t0;
        int unsigned k;
        t0 = clock_ms;
        k  = $urandom_range(1, 4);
        for (int i = 1; i <= k; i++)
            emit(lvl, t0 + dur * i / k);
    endtask

    // contact chatter ending at lvl, each step at most half the debounce
    task automatic chatter(input logic lvl);
        int unsigned n;
        n = 2 * $urandom_range(0, 2);
        for (int i = 0; i <= n; i++)
            emit((i % 2 == 0) ? lvl : !lvl,
                 clock_ms + $urandom_range(0, thr_debounce / 2));
    endtask

    // one burst of presses; the last may be held long, then the gap lapses
    task automatic one_gesture(input int unsigned presses);
        int unsigned d;
        int unsigned g;
        int unsigned l;
        logic        is_last;
        d = 32'(thr_debounce);
        g = 32'(thr_gap);
        l = 32'(thr_hold);
        for (int p = 0; p < presses; p++)
        begin
            is_last = (p == presses - 1);
            chatter(1'b1);
            hold_level(1'b1, d + (is_last ? $urandom_range(0, l + l / 2)
                                          : $urandom_range(0, l / 2)));
            chatter(1'b0);
            hold_level(1'b0, is_last ? d + g + $urandom_range(0, g)
                                     : d + $urandom_range(0, g / 3));
        end
    endtask

    // random levels, mostly near in time, some anywhere on the clock
    task automatic noise_run(input int unsigned n);
        for (int i = 0; i < n; i++)
            emit(1'($urandom_range(0, 1)),
                 ($urandom_range(0, 3) == 0) ? $urandom()
                                             : clock_ms + $urandom_range(0, 2 * thr_debounce + 2));
    endtask

    // reset
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // main sequence
    initial
    begin
        int unsigned d;
        int unsigned g;
        int unsigned l;

        // directed samples at the reset thresholds: exact boundaries,
        // chatter, short and long gestures, wrap and out-of-order stamps
        for (int i = 0; i < 25; i++)
            emit(warmup[i][32], warmup[i][31:0]);

        for (int ph = 0; ph < 7; ph++)
        begin
            wait_idle();
            d = ph_deb[ph];
            g = ph_gap[ph];
            l = ph_hold[ph];
            // last setting drawn at random
            if (ph == 6)
            begin
                d = $urandom_range(0, 15);
                g = $urandom_range(6 * d, 200);
                l = $urandom_range(0, 400);
            end
            write_reg(ADDR_DEBOUNCE, d[THR_W-1:0]);
            write_reg(ADDR_MULTI_GAP, g[THR_W-1:0]);
            write_reg(ADDR_LONG_HOLD, l[THR_W-1:0]);
            send_idle_pct  = ph_send[ph];
            recv_stall_pct = ph_recv[ph];
            // fill the block against a long hold-off
            if (ph == 0)
                hold_arm = !hold_arm;
            clock_ms = $urandom();
            // press count saturation
            if (ph == 3)
                one_gesture(17);
            while (queued_cnt < ph_end[ph])
            begin
                if ($urandom_range(7) == 0)
                    noise_run($urandom_range(4, 12));
                else
                    one_gesture(($urandom_range(9) == 0) ? $urandom_range(14, 18)
                                                         : $urandom_range(1, 4));
            end
        end
        wait_idle();

        if (err_cnt == 0 && gesture_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: FAIL");
        $finish;
    end

endmodule
